// ===== sv/abps_pkg.sv =====
// Shared types and constants of the alert beep pattern sequencer.
// No dependencies; every other file but abps_fifo imports this package.
`default_nettype none
package abps_pkg;

  // Alert codes, highest priority first
  localparam logic [1:0] ALERT_NONE = 2'd0;
  localparam logic [1:0] ALERT_TEMP = 2'd1;
  localparam logic [1:0] ALERT_SIG  = 2'd2;
  localparam logic [1:0] ALERT_VOLT = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_EN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_EN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_EN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TX_WARN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RX_WARN     = 3'd6;
  localparam int CFG_DATA_W = 16;

  // Thresholds in tenths of a degree
  localparam logic signed [11:0] TEMP_HOT  = 12'sd850;
  localparam logic signed [11:0] BOARD_HOT = 12'sd700;

  // Pattern timing in ms and initial phase counts (2*pulses-1)
  localparam logic [7:0] TEMP_OFF_MS = 8'd80;
  localparam logic [7:0] SIG_OFF_MS  = 8'd50;
  localparam logic [7:0] VOLT_OFF_MS = 8'd150;
  localparam logic [3:0] TEMP_PHASES = 4'd7;
  localparam logic [3:0] SIG_PHASES  = 4'd5;
  localparam logic [3:0] VOLT_PHASES = 4'd3;
  localparam logic [7:0] MIN_ON_MS   = 8'd20;

  // floor(4v/5) as (v*820)>>10, exact for v below 128
  localparam logic [9:0] FIFTH_MUL = 10'd820;
  localparam int         FIFTH_SHIFT = 10;

  localparam logic [6:0] VOLUME_RESET = 7'd100;
  localparam logic [15:0] WARN_RESET  = 16'd3500;

  // Classified tick handed from front to back
  typedef struct packed {
    logic [1:0]  alert;
    logic [7:0]  on_ms;
    logic [7:0]  off_ms;
    logic [3:0]  phases;
    logic [31:0] now_ms;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic       buzzer_drive;
    logic [1:0] active_alert;
    logic [3:0] phases_left;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/abps_fifo.sv =====
// Small flip-flop queue with push/full and pop/empty sides.
// Generic; WIDTH and DEPTH (at least 2) set storage. No package use.
`default_nettype none
module abps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/abps_front.sv =====
// Front end: configuration registers and alert classification of each tick.
// Depends on abps_pkg for register indexes, thresholds and item_t.
`default_nettype none
module abps_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [abps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [abps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [31:0]                     now_ms,
  input  wire logic signed [11:0]              motor_temp,
  input  wire logic signed [11:0]              esc_temp,
  input  wire logic signed [11:0]              board_temp,
  input  wire logic                            link_up,
  input  wire logic [15:0]                     tx_volt_mv,
  input  wire logic                            rx_volt_valid,
  input  wire logic [15:0]                     rx_volt_mv,
  output abps_pkg::item_t                      item
);
  import abps_pkg::*;

  logic        mute_r, temp_en_r, sig_en_r, volt_en_r;
  logic [6:0]  volume_r;
  logic [15:0] tx_warn_r, rx_warn_r;

  logic        t_al, s_al, v_al, silent;
  logic [16:0] fifth_prod;
  logic [7:0]  on_temp, on_sig, on_volt, on_raw;
  logic [8:0]  vol_x3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r    <= 1'b0;
      volume_r  <= VOLUME_RESET;
      temp_en_r <= 1'b1;
      sig_en_r  <= 1'b1;
      volt_en_r <= 1'b1;
      tx_warn_r <= WARN_RESET;
      rx_warn_r <= WARN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MUTE:    mute_r    <= cfg_wdata[0];
        REG_VOLUME:  volume_r  <= cfg_wdata[6:0];
        REG_TEMP_EN: temp_en_r <= cfg_wdata[0];
        REG_SIG_EN:  sig_en_r  <= cfg_wdata[0];
        REG_VOLT_EN: volt_en_r <= cfg_wdata[0];
        REG_TX_WARN: tx_warn_r <= cfg_wdata;
        REG_RX_WARN: rx_warn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Scaled on times: 80*v/100, 50*v/100 and 150*v/100, floored
  assign fifth_prod = 17'(volume_r) * 17'(FIFTH_MUL);
  assign on_temp    = 8'(fifth_prod >> FIFTH_SHIFT);
  assign on_sig     = 8'(volume_r >> 1);
  assign vol_x3     = 9'(volume_r) + {1'b0, volume_r, 1'b0};
  assign on_volt    = vol_x3[8:1];

  assign silent = mute_r || (volume_r == '0);
  assign t_al = temp_en_r &&
                ((motor_temp > TEMP_HOT) || (esc_temp > TEMP_HOT) || (board_temp > BOARD_HOT));
  assign s_al = sig_en_r && !link_up;
  assign v_al = volt_en_r &&
                ((tx_volt_mv < tx_warn_r) || (rx_volt_valid && (rx_volt_mv < rx_warn_r)));

  always_comb begin
    item.now_ms = now_ms;
    item.alert  = ALERT_NONE;
    item.off_ms = TEMP_OFF_MS;
    item.phases = TEMP_PHASES;
    on_raw      = on_temp;
    if (silent) begin
      item.alert = ALERT_NONE;
    end else if (t_al) begin
      item.alert = ALERT_TEMP;
    end else if (s_al) begin
      item.alert  = ALERT_SIG;
      item.off_ms = SIG_OFF_MS;
      item.phases = SIG_PHASES;
      on_raw      = on_sig;
    end else if (v_al) begin
      item.alert  = ALERT_VOLT;
      item.off_ms = VOLT_OFF_MS;
      item.phases = VOLT_PHASES;
      on_raw      = on_volt;
    end
    item.on_ms = (on_raw < MIN_ON_MS) ? MIN_ON_MS : on_raw;
  end

endmodule
`default_nettype wire

// ===== sv/abps_back.sv =====
// Back end: burst state and buzzer phase sequencing, one tick per cycle while the result queue is not full.
// Depends on abps_pkg for item_t, res_t and the alert codes.
`default_nettype none
module abps_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_vld,
  input  wire abps_pkg::item_t  item,
  output logic                  item_take,
  input  wire logic             res_full,
  output logic                  res_push,
  output abps_pkg::res_t        res
);
  import abps_pkg::*;

  logic        sounding_r, sounding_nxt;
  logic        active_r, active_nxt;
  logic [1:0]  balert_r, balert_nxt;
  logic [3:0]  pc_r, pc_nxt;
  logic [7:0]  on_r, on_nxt, off_r, off_nxt;
  logic [31:0] last_r, last_nxt;

  logic        start, eff_snd;
  logic [3:0]  eff_pc;
  logic [7:0]  eff_on, eff_off, limit;
  logic [31:0] eff_last, elapsed;

  assign item_take = item_vld && !res_full;
  assign res_push  = item_take;

  assign start    = (item.alert != ALERT_NONE) && (!active_r || (item.alert != balert_r));
  assign eff_on   = start ? item.on_ms  : on_r;
  assign eff_off  = start ? item.off_ms : off_r;
  assign eff_pc   = start ? item.phases : pc_r;
  assign eff_snd  = start ? 1'b1        : sounding_r;
  assign eff_last = start ? item.now_ms : last_r;
  assign elapsed  = item.now_ms - eff_last;
  assign limit    = eff_snd ? eff_on : eff_off;

  always_comb begin
    sounding_nxt = sounding_r;
    active_nxt   = active_r;
    balert_nxt   = balert_r;
    pc_nxt       = pc_r;
    on_nxt       = on_r;
    off_nxt      = off_r;
    last_nxt     = last_r;
    if (item.alert == ALERT_NONE) begin
      // clear burst, keep timing
      sounding_nxt = 1'b0;
      active_nxt   = 1'b0;
      balert_nxt   = ALERT_NONE;
      pc_nxt       = '0;
    end else begin
      active_nxt = 1'b1;
      balert_nxt = item.alert;
      on_nxt     = eff_on;
      off_nxt    = eff_off;
      last_nxt   = eff_last;
      pc_nxt     = eff_pc;
      if (eff_pc == '0) begin
        sounding_nxt = 1'b0;
      end else if (elapsed >= 32'(limit)) begin
        sounding_nxt = !eff_snd;
        last_nxt     = item.now_ms;
        pc_nxt       = eff_pc - 1'b1;
      end else begin
        sounding_nxt = eff_snd;
      end
    end
  end

  assign res.buzzer_drive = sounding_nxt;
  assign res.active_alert = item.alert;
  assign res.phases_left  = pc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sounding_r <= 1'b0;
      active_r   <= 1'b0;
      balert_r   <= ALERT_NONE;
      pc_r       <= '0;
      on_r       <= '0;
      off_r      <= '0;
      last_r     <= '0;
    end else if (item_take) begin
      sounding_r <= sounding_nxt;
      active_r   <= active_nxt;
      balert_r   <= balert_nxt;
      pc_r       <= pc_nxt;
      on_r       <= on_nxt;
      off_r      <= off_nxt;
      last_r     <= last_nxt;
    end
  end

  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= TEMP_PHASES) else $error("phase count beyond longest burst");

  a_active_alert: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (balert_r != ALERT_NONE)) else $error("active burst without alert");

  a_spent_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && (res.phases_left == '0)) |-> !res.buzzer_drive)
    else $error("buzzer sounding after burst spent");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && (item.alert == ALERT_NONE)) |=> (!active_r && !sounding_r && (pc_r == '0)))
    else $error("burst not cleared");

endmodule
`default_nettype wire

// ===== sv/alert_beep_pattern_sequencer_top.sv =====
// Path: a tick is classified as it is pushed into the mid queue; the back end
// takes it from the queue head and registers its result in the out queue, which feeds the out_ ports.
// Throughput: one tick per cycle while the out queue is not full; the sequencer
// handles one tick at a time and its state update is the only loop.
// Reset (rst_n low, synchronous) empties both queues, clears the burst
// state and loads the register defaults; no clearing pass.
// Depends on abps_pkg, abps_fifo, abps_front and abps_back.
`default_nettype none
module alert_beep_pattern_sequencer_top #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [abps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [abps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [31:0]                     in_now_ms,
  input  wire logic signed [11:0]              in_motor_temp,
  input  wire logic signed [11:0]              in_esc_temp,
  input  wire logic signed [11:0]              in_board_temp,
  input  wire logic                            in_link_up,
  input  wire logic [15:0]                     in_tx_volt_mv,
  input  wire logic                            in_rx_volt_valid,
  input  wire logic [15:0]                     in_rx_volt_mv,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic                                 out_buzzer_drive,
  output logic [1:0]                           out_active_alert,
  output logic [3:0]                           out_phases_left
);
  import abps_pkg::*;

  item_t front_item, mid_item;
  res_t  back_res, out_res;
  logic  mid_empty, mid_take, out_full, res_push;

  assign cfg_ready = 1'b1;

  abps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .now_ms        (in_now_ms),
    .motor_temp    (in_motor_temp),
    .esc_temp      (in_esc_temp),
    .board_temp    (in_board_temp),
    .link_up       (in_link_up),
    .tx_volt_mv    (in_tx_volt_mv),
    .rx_volt_valid (in_rx_volt_valid),
    .rx_volt_mv    (in_rx_volt_mv),
    .item          (front_item)
  );

  abps_fifo #(.WIDTH($bits(item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_item),
    .full  (in_full),
    .pop   (mid_take),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  abps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (!mid_empty),
    .item      (mid_item),
    .item_take (mid_take),
    .res_full  (out_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  abps_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_buzzer_drive = out_res.buzzer_drive;
  assign out_active_alert = out_res.active_alert;
  assign out_phases_left  = out_res.phases_left;

endmodule
`default_nettype wire
